// ===== rtl/core/isr_pkg.sv =====
// Shared types and defaults of the integer square root block.
// Depends on nothing; compiled before every other file of the block.
`default_nettype none

package isr_pkg;

	localparam int unsigned VALUE_BITS_DEF = 32;

	typedef struct packed {
		logic valid;
		logic bypass;
	} ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/isr_value_if.sv =====
// Input channel of the integer square root block: valid, ready and the value.
// Depends on isr_pkg for the default width.
`default_nettype none

interface isr_value_if #(
	parameter int unsigned WIDTH = isr_pkg::VALUE_BITS_DEF
);
	logic                    valid;
	logic                    ready;
	logic signed [WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/isr_root_if.sv =====
// Output channel of the integer square root block: valid, ready and the root.
// Depends on isr_pkg for the default width.
`default_nettype none

interface isr_root_if #(
	parameter int unsigned WIDTH = isr_pkg::VALUE_BITS_DEF
);
	logic                    valid;
	logic                    ready;
	logic signed [WIDTH-1:0] root;

	modport source (output valid, output root, input ready);
	modport sink   (input valid, input root, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/isr_cell.sv =====
// One cell of the root chain: decides a single root bit by a trial square.
// Depends on isr_pkg for the control struct.
`default_nettype none

module isr_cell #(
	parameter int unsigned VALUE_BITS = isr_pkg::VALUE_BITS_DEF,
	parameter int unsigned BIT        = 0
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       adv,
	input  wire isr_pkg::ctl_t              ctl_in,
	input  wire logic [VALUE_BITS-1:0]      x_in,
	input  wire logic [VALUE_BITS/2-1:0]    u_in,
	input  wire logic [VALUE_BITS-1:0]      u2_in,
	output isr_pkg::ctl_t                   ctl_out,
	output logic      [VALUE_BITS-1:0]      x_out,
	output logic      [VALUE_BITS/2-1:0]    u_out,
	output logic      [VALUE_BITS-1:0]      u2_out
);
	import isr_pkg::*;

	localparam int unsigned ROOT_BITS = VALUE_BITS / 2;
	localparam logic [VALUE_BITS-1:0] V_SQ =
		{{(VALUE_BITS-1){1'b0}}, 1'b1} << (2 * BIT);
	localparam logic [ROOT_BITS-1:0] V_BIT =
		{{(ROOT_BITS-1){1'b0}}, 1'b1} << BIT;

	logic [VALUE_BITS-1:0] uv2;
	logic [VALUE_BITS-1:0] trial;
	logic                  fits;

	always_comb begin
		uv2   = {{(VALUE_BITS-ROOT_BITS){1'b0}}, u_in} << (BIT + 1);
		trial = u2_in + uv2 + V_SQ;
		fits  = (trial <= x_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (adv) begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_out <= x_in;
			if (fits) begin
				u_out  <= u_in | V_BIT;
				u2_out <= trial;
			end else begin
				u_out  <= u_in;
				u2_out <= u2_in;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/integer_square_root.sv =====
// Floor square root of a signed integer. Values below two, negative ones
// included, come back unchanged. A chain of VALUE_BITS/2 cells decides one
// root bit per cell, most significant first, and the item moves one cell per
// cycle while the chain does not hold. One item is in the chain at a time and
// the input opens as the result is registered, so a new value is not taken
// until the last one has left the chain; the output register lets the next
// item start while a result waits, and the chain holds when an item reaches
// the last cell while the output register still holds a result not yet taken.
// Depends on isr_pkg, isr_value_if, isr_root_if and isr_cell.
`default_nettype none

module integer_square_root #(
	parameter int unsigned VALUE_BITS = isr_pkg::VALUE_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	isr_value_if.sink   feed,
	isr_root_if.source  result
);
	import isr_pkg::*;

	localparam int unsigned ROOT_BITS = VALUE_BITS / 2;

	ctl_t                  ctl_c [ROOT_BITS+1];
	logic [VALUE_BITS-1:0] x_c   [ROOT_BITS+1];
	logic [ROOT_BITS-1:0]  u_c   [ROOT_BITS+1];
	logic [VALUE_BITS-1:0] u2_c  [ROOT_BITS+1];

	logic                  busy_q;
	logic                  take;
	logic                  adv;
	logic                  done;
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] root_q;

	assign feed.ready = !busy_q;
	assign take       = feed.valid && !busy_q;
	assign done       = ctl_c[ROOT_BITS].valid;
	assign adv        = !(done && out_valid_q && !result.ready);

	assign ctl_c[0].valid  = take;
	assign ctl_c[0].bypass = feed.value[VALUE_BITS-1] || !(|feed.value[VALUE_BITS-1:1]);
	assign x_c[0]          = feed.value;
	assign u_c[0]          = '0;
	assign u2_c[0]         = '0;

	for (genvar i = 0; i < ROOT_BITS; i++) begin : g_cell
		isr_cell #(
			.VALUE_BITS (VALUE_BITS),
			.BIT        (ROOT_BITS - 1 - i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.ctl_in  (ctl_c[i]),
			.x_in    (x_c[i]),
			.u_in    (u_c[i]),
			.u2_in   (u2_c[i]),
			.ctl_out (ctl_c[i+1]),
			.x_out   (x_c[i+1]),
			.u_out   (u_c[i+1]),
			.u2_out  (u2_c[i+1])
		);
	end

	// hold busy from accept until the item leaves the last cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
			end else if (done && adv) begin
				busy_q <= 1'b0;
			end
			if (done && adv) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done && adv) begin
			root_q <= ctl_c[ROOT_BITS].bypass ? x_c[ROOT_BITS]
				: {{(VALUE_BITS-ROOT_BITS){1'b0}}, u_c[ROOT_BITS]};
		end
	end

	assign result.valid = out_valid_q;
	assign result.root  = root_q;

endmodule

`default_nettype wire

// ===== sim/isr_checker.sv =====
// Checker of the integer square root block: watches both channels, predicts each root.
// Depends on isr_value_if and isr_root_if; hands its failure count to the top.
`default_nettype none

module isr_checker #(
	parameter int unsigned W = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	isr_value_if       feed,
	isr_root_if        result,
	output int unsigned fail_count,
	output int unsigned open_items
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [W-1:0] pending_roots[$];

	function automatic logic signed [W-1:0] floor_root_of(logic signed [W-1:0] value);
		logic [2*W-1:0] n;
		logic [2*W-1:0] root;
		logic [2*W-1:0] root_sq;
		logic [2*W-1:0] trial;
		logic [2*W-1:0] one;
		int lead;
		int half;
		if (value < 2)
			return value;
		n = {{W{1'b0}}, value};
		one = 1;
		lead = 0;
		for (int b = 0; b < W; b++)
			if (value[b])
				lead = b;
		half = lead / 2;
		root = one << half;
		root_sq = root << half;
		for (int b = half - 1; b >= 0; b--) begin
			trial = root_sq + (root << (b + 1)) + (one << (2 * b));
			if (trial <= n) begin
				root[b] = 1'b1;
				root_sq = trial;
			end
		end
		return root[W-1:0];
	endfunction

	initial begin
		fail_count <= 0;
		open_items <= 0;
	end

	always @(posedge clk) begin
		logic signed [W-1:0] want;
		if (arst_n) begin
			if (feed.valid && feed.ready)
				pending_roots.push_back(floor_root_of(feed.value));
			if (result.valid && result.ready) begin
				if (pending_roots.size() == 0) begin
					$error("root: no item pending, actual %0d", result.root);
					fail_count <= fail_count + 1;
				end else begin
					want = pending_roots.pop_front();
					if (result.root !== want) begin
						$error("root: expected %0d, actual %0d", want, result.root);
						fail_count <= fail_count + 1;
					end
				end
			end
			open_items <= pending_roots.size();
		end
	end

endmodule

`default_nettype wire

// ===== sim/tb_integer_square_root.sv =====
// Top of the integer square root testbench: clock, reset, stimulus and verdict.
// Depends on isr_pkg, the channel interfaces, integer_square_root and isr_checker.
`default_nettype none

module tb_integer_square_root;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned W = isr_pkg::VALUE_BITS_DEF;
	localparam int unsigned LATENCY = W / 2 + 1;
	localparam int unsigned LONG_HOLD = 200;
	localparam int unsigned QUIET_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n;
	logic sender_idles;
	logic receiver_idles;
	logic hold_off_due = 1'b0;
	int unsigned mismatch_total;
	int unsigned open_items;
	int unsigned quiet_cycles = 0;
	logic signed [W-1:0] corners[$];

	isr_value_if #(.WIDTH(W)) feed_ch ();
	isr_root_if  #(.WIDTH(W)) root_ch ();

	integer_square_root #(.VALUE_BITS(W)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed_ch),
		.result (root_ch)
	);

	isr_checker #(.W(W)) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed       (feed_ch),
		.result     (root_ch),
		.fail_count (mismatch_total),
		.open_items (open_items)
	);

	always #1 clk = ~clk;

	function automatic logic signed [W-1:0] draw_value();
		logic [W-1:0] raw;
		raw = $urandom;
		case ($urandom_range(0, 9))
			0, 1: return {1'b1, raw[W-2:0]};
			2: return $urandom_range(0, 300);
			3: begin
				raw = $urandom_range(0, 46340);
				raw = raw * raw + $urandom_range(0, 2) - 1;
				return raw;
			end
			4, 5, 6: return {1'b0, raw[W-2:0]} >> $urandom_range(0, W - 2);
			default: return {1'b0, raw[W-2:0]};
		endcase
	endfunction

	task automatic send_value(input logic signed [W-1:0] value);
		int unsigned gap;
		gap = sender_idles ? $urandom_range(0, 19) : 0;
		if (gap != 0) begin
			feed_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		feed_ch.valid <= 1'b1;
		feed_ch.value <= value;
		do @(posedge clk); while (!feed_ch.ready);
	endtask

	task automatic drain_results();
		feed_ch.valid <= 1'b0;
		do @(posedge clk); while (open_items != 0);
	endtask

	// receiver
	initial begin
		int unsigned stall;
		root_ch.ready <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (hold_off_due) begin
				root_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_off_due = 1'b0;
			end
			stall = receiver_idles ? $urandom_range(0, 19) : 0;
			if (stall != 0) begin
				root_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			root_ch.ready <= 1'b1;
			do @(posedge clk); while (!root_ch.valid);
		end
	end

	always @(posedge clk) begin
		if ((feed_ch.valid && feed_ch.ready) || (root_ch.valid && root_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_integer_square_root: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		feed_ch.valid <= 1'b0;
		feed_ch.value <= '0;
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
		corners = '{0, 1, -1, 2, 3, 4, 5, 8, 15, 16, 24, 25, 99, 100, 65535, 65536,
			32'h2000_0000, 32'h3fff_ffff, 32'h4000_0000, 2147395599, 2147395600,
			32'h7fff_ffff, 32'h8000_0000, 32'hffff_fffe};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corners[i])
			send_value(corners[i]);
		drain_results();

		sender_idles = 1'b0;
		hold_off_due = 1'b1;
		repeat (12) send_value(draw_value());
		drain_results();

		for (int block = 0; block < 8; block++) begin
			sender_idles = (block % 4) < 2;
			receiver_idles = (block % 2) == 0;
			repeat (100) send_value(draw_value());
		end
		drain_results();
		repeat (LATENCY + 8) @(posedge clk);

		if (mismatch_total == 0 && open_items == 0)
			$display("tb_integer_square_root: PASS");
		else
			$display("tb_integer_square_root: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
